// ===== sv/http_chunked_dechunker_defines.svh =====
// Assertion macros for the chunked body decoder checker.
// Depends on a clock named aclk and a synchronous active-low reset aresetn in scope.
`ifndef HTTP_CHUNKED_DECHUNKER_DEFINES_SVH
`define HTTP_CHUNKED_DECHUNKER_DEFINES_SVH

// Property checked only outside reset.
`define HCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define HCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/hcd_pkg.sv =====
// Shared types, codes and character helpers for the chunked body decoder.
// No dependencies.
package hcd_pkg;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_TRAIL,
        PH_STOP
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DATA  = 2'd0;
    localparam kind_t KIND_END   = 2'd1;
    localparam kind_t KIND_NODIG = 2'd2;
    localparam kind_t KIND_BIG   = 2'd3;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [1:0] SKIP_TRAIL = 2'd2;

    typedef struct packed {
        logic digit_seen;
        logic digits_closed;
        logic prev_was_cr;
        logic too_big;
    } line_flags_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      result_kind;
        logic       chunk_last;
    } result_t;

    // Space and the range tab through CR.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // {valid, value} of one hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== sv/hcd_core.sv =====
// Parse state registers and the per-byte step logic of the chunked body decoder.
// Depends on hcd_pkg.
module hcd_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic [7:0]      in_byte,
    input  logic            first_of_body,
    output logic            res_valid,
    output hcd_pkg::result_t res
);
    import hcd_pkg::*;

    phase_t                phase_reg, phase_next, phase_e;
    logic [SIZE_BITS-1:0]  acc_reg, acc_next, acc_e;
    logic [SIZE_BITS-1:0]  left_reg, left_next, left_e, left_dec;
    line_flags_t           flags_reg, flags_next, flags_e;
    logic [1:0]            skip_reg, skip_next, skip_e, skip_dec;
    logic [4:0]            hv;
    logic                  closed_a;
    logic                  lf_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SIZE;
            acc_reg   <= '0;
            left_reg  <= '0;
            flags_reg <= '0;
            skip_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
        end
    end

    always_comb begin
        // start of body wipes everything before this byte is looked at
        phase_e = first_of_body ? PH_SIZE : phase_reg;
        acc_e   = first_of_body ? '0 : acc_reg;
        left_e  = first_of_body ? '0 : left_reg;
        flags_e = first_of_body ? '0 : flags_reg;
        skip_e  = first_of_body ? '0 : skip_reg;

        phase_next = phase_e;
        acc_next   = acc_e;
        left_next  = left_e;
        flags_next = flags_e;
        skip_next  = skip_e;
        res_valid  = 1'b0;
        res        = '0;

        hv       = hex_value(in_byte);
        closed_a = flags_e.digits_closed;
        lf_end   = 1'b0;
        left_dec = (left_e != '0) ? left_e - 1'b1 : left_e;
        skip_dec = (skip_e != 2'd0) ? skip_e - 2'd1 : skip_e;

        unique case (phase_e)
            PH_SIZE: begin
                if (flags_e.prev_was_cr) begin
                    flags_next.prev_was_cr = 1'b0;
                    if (in_byte == CHAR_LF) begin
                        lf_end     = 1'b1;
                        flags_next = '0;
                        acc_next   = '0;
                        if (!flags_e.too_big && flags_e.digit_seen && acc_e != '0) begin
                            left_next  = acc_e;
                            phase_next = PH_DATA;
                        end else begin
                            res_valid  = 1'b1;
                            phase_next = PH_STOP;
                            if (flags_e.too_big) begin
                                res.result_kind = KIND_BIG;
                            end else if (!flags_e.digit_seen) begin
                                res.result_kind = KIND_NODIG;
                            end else begin
                                res.result_kind = KIND_END;
                            end
                        end
                    end else begin
                        // lone CR acts as a blank: closes digits once one was seen
                        closed_a = flags_e.digits_closed | flags_e.digit_seen;
                    end
                end
                if (!lf_end) begin
                    flags_next.digits_closed = closed_a;
                    if (in_byte == CHAR_CR) begin
                        flags_next.prev_was_cr = 1'b1;
                    end else if (!closed_a) begin
                        if (!hv[4]) begin
                            if (flags_e.digit_seen || !is_blank(in_byte)) begin
                                flags_next.digits_closed = 1'b1;
                            end
                        end else begin
                            flags_next.digit_seen = 1'b1;
                            if (acc_e[SIZE_BITS-1 -: 4] != 4'd0) begin
                                flags_next.too_big = 1'b1;
                            end else begin
                                acc_next = {acc_e[SIZE_BITS-5:0], hv[3:0]};
                            end
                        end
                    end
                end
            end
            PH_DATA: begin
                left_next       = left_dec;
                res_valid       = 1'b1;
                res.out_byte    = in_byte;
                res.result_kind = KIND_DATA;
                res.chunk_last  = (left_dec == '0);
                if (left_dec == '0) begin
                    phase_next = PH_TRAIL;
                    skip_next  = SKIP_TRAIL;
                end
            end
            PH_TRAIL: begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0) begin
                    phase_next = PH_SIZE;
                    flags_next = '0;
                    acc_next   = '0;
                end
            end
            PH_STOP: begin
                // drop bytes until the next start of body
            end
        endcase
    end

endmodule

// ===== sv/hcd_out_reg.sv =====
// Result register of the chunked body decoder, held until the sink takes the beat.
// Depends on hcd_pkg.
module hcd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  hcd_pkg::result_t load_data,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [7:0]       m_out_byte,
    output logic [1:0]       m_result_kind,
    output logic             m_chunk_last
);
    import hcd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = data_reg.out_byte;
    assign m_result_kind = data_reg.result_kind;
    assign m_chunk_last  = data_reg.chunk_last;

endmodule

// ===== sv/http_chunked_dechunker.sv =====
// Top level of the chunked body decoder: input register, parse core, result register.
// Depends on hcd_pkg, hcd_core and hcd_out_reg.
//
//  channel | direction | ports
//  --------+-----------+----------------------------------------------------
//  s_      | in        | s_valid s_ready s_in_byte s_first_of_body
//  m_      | out       | m_valid m_ready m_out_byte m_result_kind m_chunk_last
//
// One byte per cycle unless the sink stalls; a byte's result is registered in the output register.
// The rate is set by the parse state update in hcd_core, done once per byte.
// aresetn is synchronous and clears both stage valids and the parse state.
// A stalled result holds in the output register; one more byte waits in the
// input register, and s_ready drops only when both are full.
module http_chunked_dechunker #(
    parameter int SIZE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_first_of_body,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_result_kind,
    output logic       m_chunk_last
);
    import hcd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    // the byte moves into the core when the result register is free or draining
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_in_byte;
            in_first_reg <= s_first_of_body;
        end
    end

    hcd_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_byte      (in_byte_reg),
        .first_of_body(in_first_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    hcd_out_reg u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance && res_valid),
        .load_data    (res),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_result_kind(m_result_kind),
        .m_chunk_last (m_chunk_last)
    );

endmodule

// ===== sv/hcd_checker.sv =====
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on hcd_pkg and http_chunked_dechunker_defines.svh.
`include "http_chunked_dechunker_defines.svh"

module hcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       s_first_of_body,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_result_kind,
    input logic       m_chunk_last
);
    import hcd_pkg::*;

    logic status_beat;

    assign status_beat = m_valid && (m_result_kind != KIND_DATA);

    `HCD_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `HCD_ASSERT(a_hold_valid, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `HCD_ASSERT(a_status_clean, status_beat |-> m_out_byte == 8'd0 && !m_chunk_last, "status beat with payload")
    `HCD_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with empty output")

endmodule

bind http_chunked_dechunker hcd_checker u_hcd_checker (.*);

// ===== verif/hcd_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the chunked body decoder: watches both channels, predicts results per byte.
// Depends on hcd_pkg for phases, result kinds, character codes and the result struct.
module hcd_scoreboard #(
    parameter int SIZE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_first_of_body,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic [1:0] m_result_kind,
    input  logic       m_chunk_last,
    output int         mismatch_total,
    output int         open_count
);
    import hcd_pkg::*;

    phase_t               dec_phase;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] payload_left;
    line_flags_t          line;
    logic [1:0]           trailer_left;
    result_t              expected_q[$];
    int                   errs;

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic clear_line();
        size_acc = '0;
        line     = '0;
    endtask

    // One character of the size line, the closing CR LF excluded.
    task automatic take_line_char(input logic [7:0] c);
        int v;
        logic [3:0] nib;
        v = hex_digit(c);
        nib = v[3:0];
        if (line.digits_closed) return;
        if (v < 0) begin
            if (!line.digit_seen && blank_char(c)) return;
            line.digits_closed = 1'b1;
            return;
        end
        line.digit_seen = 1'b1;
        if (size_acc[SIZE_BITS-1 -: 4] != '0) begin
            line.too_big = 1'b1;
            return;
        end
        size_acc = {size_acc[SIZE_BITS-5:0], nib};
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic first);
        result_t r;
        r = '0;
        if (first) begin
            dec_phase    = PH_SIZE;
            payload_left = '0;
            trailer_left = '0;
            clear_line();
        end
        case (dec_phase)
            PH_SIZE: begin
                if (line.prev_was_cr) begin
                    line.prev_was_cr = 1'b0;
                    if (c == CHAR_LF) begin
                        if (line.too_big || !line.digit_seen || size_acc == '0) begin
                            if (line.too_big) r.result_kind = KIND_BIG;
                            else if (!line.digit_seen) r.result_kind = KIND_NODIG;
                            else r.result_kind = KIND_END;
                            dec_phase = PH_STOP;
                            expected_q = {expected_q, r};
                        end else begin
                            payload_left = size_acc;
                            dec_phase    = PH_DATA;
                        end
                        clear_line();
                        return;
                    end
                    // a lone CR counts like any other character of the line
                    take_line_char(CHAR_CR);
                end
                if (c == CHAR_CR) line.prev_was_cr = 1'b1;
                else take_line_char(c);
            end
            PH_DATA: begin
                if (payload_left != '0) payload_left = payload_left - 1'b1;
                r.out_byte    = c;
                r.result_kind = KIND_DATA;
                r.chunk_last  = (payload_left == '0);
                if (r.chunk_last) begin
                    dec_phase    = PH_TRAIL;
                    trailer_left = SKIP_TRAIL;
                end
                expected_q = {expected_q, r};
            end
            PH_TRAIL: begin
                if (trailer_left != '0) trailer_left = trailer_left - 1'b1;
                if (trailer_left == '0) begin
                    dec_phase = PH_SIZE;
                    clear_line();
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            dec_phase    = PH_SIZE;
            payload_left = '0;
            trailer_left = '0;
            clear_line();
            expected_q.delete();
            errs = 0;
        end else begin
            // predict first so a beat is never compared before its byte is seen
            if (s_valid && s_ready) decode_byte(s_in_byte, s_first_of_body);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result beat: byte %02h kind %0d last %0b",
                                 m_out_byte, m_result_kind, m_chunk_last);
                end else begin
                    want = expected_q.pop_front();
                    if (want.out_byte !== m_out_byte || want.result_kind !== m_result_kind ||
                        want.chunk_last !== m_chunk_last) begin
                        errs++;
                        if (errs <= 10)
                            $display("mismatch: exp %02h/%0d/%0b got %02h/%0d/%0b",
                                     want.out_byte, want.result_kind, want.chunk_last,
                                     m_out_byte, m_result_kind, m_chunk_last);
                    end
                end
            end
        end
        mismatch_total <= errs;
        open_count     <= expected_q.size();
    end

endmodule

// ===== verif/tb_http_chunked_dechunker.sv =====
`timescale 1ns / 1ps
// Top of the chunked body decoder testbench: clock, reset, byte stimulus and the verdict.
// Depends on hcd_pkg, http_chunked_dechunker and hcd_scoreboard.
module tb_http_chunked_dechunker;
    import hcd_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_START   = 500;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 5000;

    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_first_of_body;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic [1:0] m_result_kind;
    logic       m_chunk_last;
    int         mismatches;
    int         pending;
    int         idle_cycles;

    logic [7:0] stim_bytes[$];
    logic       stim_starts[$];
    logic       next_start;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    http_chunked_dechunker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_byte(s_in_byte), .s_first_of_body(s_first_of_body),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_byte(m_out_byte), .m_result_kind(m_result_kind), .m_chunk_last(m_chunk_last)
    );

    hcd_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_byte(s_in_byte), .s_first_of_body(s_first_of_body),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_byte(m_out_byte), .m_result_kind(m_result_kind), .m_chunk_last(m_chunk_last),
        .mismatch_total(mismatches), .open_count(pending)
    );

    task automatic put_beat(input logic [7:0] b);
        stim_bytes  = {stim_bytes, b};
        stim_starts = {stim_starts, next_start};
        next_start = 1'b0;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_beat(s[i]);
    endtask

    task automatic put_crlf();
        put_beat(CHAR_CR);
        put_beat(CHAR_LF);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            3: return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) return "0" + v;
        return (upper ? "A" : "a") + v - 8'd10;
    endfunction

    task automatic put_lead_blanks();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) put_beat(pick_blank());
        // lone CR before the digits acts as a blank
        if ($urandom_range(0, 9) == 0) begin
            put_beat(CHAR_CR);
            put_beat(CHAR_SPACE);
        end
    endtask

    task automatic put_digits(input logic [39:0] value);
        int nd;
        nd = 1;
        while (nd < 10 && (value >> (4 * nd)) != 0) nd++;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) put_beat("0");
        for (int i = nd - 1; i >= 0; i--) begin
            put_beat(hex_char(value[4*i +: 4], 1'($urandom_range(0, 1))));
        end
    endtask

    // Anything after the digits up to CR LF; none of it contains a CR followed by LF.
    task automatic put_line_tail();
        case ($urandom_range(0, 9))
            0, 1: begin
                put_beat(";");
                repeat ($urandom_range(1, 4)) put_beat(8'($urandom_range(8'h21, 8'h7E)));
            end
            2: repeat ($urandom_range(1, 2)) put_beat(pick_blank());
            3: begin
                put_beat(CHAR_CR);
                put_beat(";");
            end
            4: put_beat(8'($urandom_range(8'h80, 8'hFF)));
            default: begin
            end
        endcase
        put_crlf();
    endtask

    task automatic put_size_line(input logic [39:0] value);
        put_lead_blanks();
        put_digits(value);
        put_line_tail();
    endtask

    task automatic put_chunk(input int size, input bit complete);
        int sent;
        put_size_line(40'(size));
        sent = complete ? size : $urandom_range(0, size - 1);
        repeat (sent) put_beat(8'($urandom_range(0, 255)));
        if (!complete) return;
        if ($urandom_range(0, 6) != 0) put_crlf();
        else repeat (2) put_beat(8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 8);
        if (r < 96) return $urandom_range(9, 40);
        return $urandom_range(41, 300);
    endfunction

    task automatic put_body();
        int r;
        logic [31:0] lo;
        logic [7:0]  hi;
        next_start = 1'b1;
        if ($urandom_range(0, 11) == 0) begin
            // noise, with the odd start of body scattered inside
            repeat ($urandom_range(1, 12)) begin
                put_beat(8'($urandom_range(0, 255)));
                next_start = ($urandom_range(0, 5) == 0);
            end
            next_start = 1'b0;
            return;
        end
        repeat ($urandom_range(0, 4)) put_chunk(pick_size(), 1'b1);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            put_lead_blanks();
            if ($urandom_range(0, 4) == 0) put_str("0x1f");
            else put_digits(40'd0);
            put_line_tail();
        end else if (r < 72) begin
            put_lead_blanks();
            case ($urandom_range(0, 4))
                0: put_beat("-");
                1: put_beat("+");
                2: put_beat(8'($urandom_range("g", "z")));
                3: put_beat(";");
                default: begin
                end
            endcase
            if ($urandom_range(0, 1)) put_digits(40'($urandom_range(1, 255)));
            put_crlf();
        end else if (r < 84) begin
            lo = $urandom;
            hi = 8'($urandom_range(1, 255));
            put_size_line({hi, lo});
        end else if (r < 92) begin
            put_chunk(pick_size() + 1, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) put_beat(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_stimulus();
        int directed;
        // two-byte chunk carrying both byte extremes
        next_start = 1'b1;
        put_str("2");
        put_crlf();
        put_beat(8'h00);
        put_beat(8'hFF);
        put_crlf();
        // lone CR then CR LF with no digits, then a byte that must be dropped
        next_start = 1'b1;
        put_beat(CHAR_CR);
        put_crlf();
        put_str("7");
        // hex prefix reads as size zero
        next_start = 1'b1;
        put_str("0x1");
        put_crlf();
        // nine digits overflow the size, mixed case
        next_start = 1'b1;
        put_str("FEdcba987");
        put_crlf();
        directed = stim_bytes.size();
        while (stim_bytes.size() < directed + RANDOM_ITEMS) put_body();
    endtask

    // Sender: bursts of random length separated by random gaps.
    initial begin
        int idx;
        int burst;
        int gap;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_in_byte       <= '0;
        s_first_of_body <= 1'b0;
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idx = 0;
        while (idx < stim_bytes.size()) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < stim_bytes.size()) begin
                s_valid         <= 1'b1;
                s_in_byte       <= stim_bytes[idx];
                s_first_of_body <= stim_starts[idx];
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && idx < stim_bytes.size()) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        // let the checker count the last beat before looking at what is open
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver: stall pattern is picked at random from four modes, with one long hold mid-run.
    initial begin
        int cyc;
        int mode;
        logic rdy;
        m_ready <= 1'b0;
        cyc  = 0;
        mode = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (cyc == HOLD_START) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                cyc += HOLD_CYCLES;
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (cyc % 4 == 0);
                    default: rdy = ($urandom_range(0, 9) != 0);
                endcase
                m_ready <= rdy;
                @(posedge aclk);
                cyc++;
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
